// File: hdl/location_expression_stack_machine_assert.svh
// Assertion macros used by the checker file of the stack machine.
`ifndef LOCATION_EXPRESSION_STACK_MACHINE_ASSERT_SVH
`define LOCATION_EXPRESSION_STACK_MACHINE_ASSERT_SVH

// Same-cycle implication, checked at every rising clock edge out of reset.
`define LESM_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("stack machine check failed");

// Next-cycle implication, checked at every rising clock edge out of reset.
`define LESM_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("stack machine check failed");

`endif

// File: hdl/lesm_pkg.sv
// Types, constants and codes shared by the stack machine modules.
package lesm_pkg;

    localparam int STACK_DEPTH = 16;
    localparam int SP_W        = $clog2(STACK_DEPTH + 1);
    localparam int IDX_W       = $clog2(STACK_DEPTH);
    localparam int DATA_W      = 64;
    localparam int DEPTH_W     = 5;
    localparam int STATUS_W    = 3;
    localparam int CMD_W       = 4;
    localparam int HALF_W      = DATA_W / 2;
    localparam int DIV_STEPS   = DATA_W;
    localparam int MUL_STEPS   = 3;
    localparam int CNT_W       = $clog2(DIV_STEPS);

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH  = 4'd0,
        CMD_STORE = 4'd1,
        CMD_ADD   = 4'd2,
        CMD_SUB   = 4'd3,
        CMD_MUL   = 4'd4,
        CMD_DIV   = 4'd5,
        CMD_AND   = 4'd6,
        CMD_OR    = 4'd7,
        CMD_XOR   = 4'd8,
        CMD_NOT   = 4'd9,
        CMD_GE    = 4'd10,
        CMD_GT    = 4'd11,
        CMD_LE    = 4'd12,
        CMD_LT    = 4'd13,
        CMD_SHL   = 4'd14,
        CMD_SHR   = 4'd15
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 3'd0,
        ST_UNDER = 3'd1,
        ST_DIVZ  = 3'd2,
        ST_OVER  = 3'd3,
        ST_HALT  = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        ADDR_TOP,
        ADDR_NEXT,
        ADDR_SP
    } t_addr_sel;

    typedef enum logic [1:0] {
        SP_HOLD,
        SP_INC,
        SP_DEC
    } t_sp_op;

    typedef enum logic [1:0] {
        TOP_KEEP,
        TOP_RES,
        TOP_NEXT
    } t_top_sel;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD_TOP,
        S_RD_NEXT,
        S_EXEC,
        S_UNIT,
        S_FINISH
    } t_state;

    typedef struct packed {
        logic [CMD_W-1:0]  command;
        logic [DATA_W-1:0] operand;
        logic              last_command;
    } t_in_req;

    typedef struct packed {
        logic [DATA_W-1:0]   top_value;
        logic [DEPTH_W-1:0]  depth;
        logic [DATA_W-1:0]   stored_value;
        logic                store_valid;
        logic [STATUS_W-1:0] status;
        logic                expression_done;
    } t_out_res;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic      cap_in;
        logic      rd_en;
        t_addr_sel rd_sel;
        logic      cap_b;
        logic      unit_start;
        logic      res_load;
        logic      res_unit;
        logic      commit;
        logic      wr_en;
        t_addr_sel wr_sel;
        t_sp_op    sp_op;
        t_top_sel  top_sel;
        logic      store_en;
        logic      set_err;
        t_status   status;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        t_cmd cmd;
        logic halted;
        logic sp_zero;
        logic sp_lt2;
        logic sp_full;
        logic b_zero;
        logic unit_done;
        logic out_free;
    } t_dp_stat;

endpackage

// File: hdl/lesm_mdu.sv
// Iterative multiply and divide unit: a shared 32x32 multiplier and a restoring divider.
module lesm_mdu (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic                      i_div,
    input  logic [lesm_pkg::DATA_W-1:0] i_a,
    input  logic [lesm_pkg::DATA_W-1:0] i_b,
    output logic                      o_done,
    output logic [lesm_pkg::DATA_W-1:0] o_result
);
    import lesm_pkg::*;

    logic              r_busy;
    logic              r_done;
    logic              r_div;
    logic [CNT_W-1:0]  r_cnt;
    logic [DATA_W-1:0] r_opa;
    logic [DATA_W-1:0] r_opb;
    logic [DATA_W-1:0] r_acc;

    logic [HALF_W-1:0] mul_x;
    logic [HALF_W-1:0] mul_y;
    logic [DATA_W-1:0] prod;
    logic [DATA_W:0]   shifted;
    logic [DATA_W:0]   diff;
    logic              fits;
    logic              last_step;

    // The low product comes first, then the two cross products shifted up.
    assign mul_x = (r_cnt == CNT_W'(2)) ? r_opa[DATA_W-1:HALF_W] : r_opa[HALF_W-1:0];
    assign mul_y = (r_cnt == CNT_W'(1)) ? r_opb[DATA_W-1:HALF_W] : r_opb[HALF_W-1:0];
    assign prod  = mul_x * mul_y;

    assign shifted = {r_acc, r_opa[DATA_W-1]};
    assign diff    = shifted - {1'b0, r_opb};
    assign fits    = !diff[DATA_W];

    assign last_step = r_div ? (r_cnt == CNT_W'(DIV_STEPS - 1))
                             : (r_cnt == CNT_W'(MUL_STEPS - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CNT_W'(1);
                if (last_step) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_div <= i_div;
            r_opa <= i_a;
            r_opb <= i_b;
            r_acc <= '0;
        end else if (r_busy) begin
            if (r_div) begin
                r_acc <= fits ? diff[DATA_W-1:0] : shifted[DATA_W-1:0];
                r_opa <= {r_opa[DATA_W-2:0], fits};
            end else if (r_cnt == '0) begin
                r_acc <= prod;
            end else begin
                r_acc <= r_acc + {prod[HALF_W-1:0], {HALF_W{1'b0}}};
            end
        end
    end

    assign o_done   = r_done;
    assign o_result = r_div ? r_opa : r_acc;

endmodule

// File: hdl/lesm_dp.sv
// Datapath: value stack memory, stack pointer, operand registers, ALU and result register.
module lesm_dp (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  lesm_pkg::t_in_req  i_in,
    input  lesm_pkg::t_dp_cmd  i_cmd,
    output lesm_pkg::t_dp_stat o_stat,
    input  logic               i_out_ready,
    output logic               o_out_valid,
    output lesm_pkg::t_out_res o_out
);
    import lesm_pkg::*;

    logic [DATA_W-1:0] r_mem [STACK_DEPTH];
    logic [DATA_W-1:0] r_rd_data;
    logic [DATA_W-1:0] r_b;
    logic [DATA_W-1:0] r_res;
    logic [DATA_W-1:0] r_operand;
    t_cmd              r_cmd;
    logic              r_last;
    logic [SP_W-1:0]   r_sp;
    logic              r_err;
    logic              r_out_valid;
    t_out_res          r_out;

    logic [SP_W-1:0]   sp_m1;
    logic [SP_W-1:0]   sp_m2;
    logic [SP_W-1:0]   n_sp;
    logic [IDX_W-1:0]  rd_idx;
    logic [IDX_W-1:0]  wr_idx;
    logic [DATA_W-1:0] alu_res;
    logic [DATA_W-1:0] unit_res;
    logic              unit_done;
    logic              out_free;
    t_out_res          n_out;

    function automatic logic [DATA_W-1:0] alu(input t_cmd cmd, input logic [DATA_W-1:0] a,
                                              input logic [DATA_W-1:0] b,
                                              input logic [DATA_W-1:0] opnd);
        logic wide;
        wide = (b >= DATA_W);
        case (cmd)
            CMD_PUSH: alu = opnd;
            CMD_ADD:  alu = a + b;
            CMD_SUB:  alu = a - b;
            CMD_AND:  alu = a & b;
            CMD_OR:   alu = a | b;
            CMD_XOR:  alu = a ^ b;
            CMD_NOT:  alu = ~b;
            CMD_GE:   alu = DATA_W'(a >= b);
            CMD_GT:   alu = DATA_W'(a > b);
            CMD_LE:   alu = DATA_W'(a <= b);
            CMD_LT:   alu = DATA_W'(a < b);
            CMD_SHL:  alu = wide ? '0 : a << b[$clog2(DATA_W)-1:0];
            CMD_SHR:  alu = wide ? '0 : a >> b[$clog2(DATA_W)-1:0];
            default:  alu = '0;
        endcase
    endfunction

    lesm_mdu u_mdu (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (i_cmd.unit_start),
        .i_div    (r_cmd == CMD_DIV),
        .i_a      (r_rd_data),
        .i_b      (r_b),
        .o_done   (unit_done),
        .o_result (unit_res)
    );

    assign sp_m1   = r_sp - SP_W'(1);
    assign sp_m2   = r_sp - SP_W'(2);
    assign rd_idx  = (i_cmd.rd_sel == ADDR_NEXT) ? sp_m2[IDX_W-1:0] : sp_m1[IDX_W-1:0];
    assign alu_res = alu(r_cmd, r_rd_data, r_b, r_operand);
    assign out_free = !r_out_valid || i_out_ready;

    always_comb begin
        unique case (i_cmd.wr_sel)
            ADDR_TOP:  wr_idx = sp_m1[IDX_W-1:0];
            ADDR_NEXT: wr_idx = sp_m2[IDX_W-1:0];
            default:   wr_idx = r_sp[IDX_W-1:0];
        endcase
    end

    always_comb begin
        unique case (i_cmd.sp_op)
            SP_INC:  n_sp = r_sp + SP_W'(1);
            SP_DEC:  n_sp = sp_m1;
            default: n_sp = r_sp;
        endcase
    end

    always_comb begin
        n_out.depth           = DEPTH_W'({{DEPTH_W{1'b0}}, n_sp});
        n_out.stored_value    = i_cmd.store_en ? r_b : '0;
        n_out.store_valid     = i_cmd.store_en;
        n_out.status          = i_cmd.status;
        n_out.expression_done = r_last;
        unique case (i_cmd.top_sel)
            TOP_RES:  n_out.top_value = r_res;
            TOP_NEXT: n_out.top_value = (r_sp < SP_W'(2)) ? '0 : r_rd_data;
            default:  n_out.top_value = (r_sp == '0) ? '0 : r_b;
        endcase
    end

    // Stack memory: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit && i_cmd.wr_en) begin
            r_mem[wr_idx] <= r_res;
        end
        if (i_cmd.rd_en) begin
            r_rd_data <= r_mem[rd_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.cap_in) begin
            r_cmd     <= t_cmd'(i_in.command);
            r_operand <= i_in.operand;
            r_last    <= i_in.last_command;
        end
        if (i_cmd.cap_b) begin
            r_b <= r_rd_data;
        end
        if (i_cmd.res_load) begin
            r_res <= i_cmd.res_unit ? unit_res : alu_res;
        end
        if (i_cmd.commit) begin
            r_out <= n_out;
        end
    end

    // A request marked last leaves an empty stack and clears the sticky error.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sp        <= '0;
            r_err       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.commit) begin
                r_sp        <= r_last ? '0 : n_sp;
                r_err       <= r_last ? 1'b0 : (r_err | i_cmd.set_err);
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_stat.cmd       = r_cmd;
    assign o_stat.halted    = r_err;
    assign o_stat.sp_zero   = (r_sp == '0);
    assign o_stat.sp_lt2    = (r_sp < SP_W'(2));
    assign o_stat.sp_full   = (r_sp >= SP_W'(STACK_DEPTH));
    assign o_stat.b_zero    = (r_b == '0);
    assign o_stat.unit_done = unit_done;
    assign o_stat.out_free  = out_free;

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

// File: hdl/lesm_ctrl.sv
// Controller: sequences stack reads, execution and commit for one request at a time.
module lesm_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  lesm_pkg::t_dp_stat i_stat,
    output lesm_pkg::t_dp_cmd  o_cmd
);
    import lesm_pkg::*;

    t_state    r_state;
    t_state    n_state;

    t_status   d_status;
    logic      d_wr;
    t_addr_sel d_wsel;
    t_sp_op    d_spop;
    t_top_sel  d_top;
    logic      d_store;
    logic      d_unit;

    // Outcome of the current command, from the stack state before it.
    always_comb begin
        d_status = ST_OK;
        d_wr     = 1'b0;
        d_wsel   = ADDR_SP;
        d_spop   = SP_HOLD;
        d_top    = TOP_KEEP;
        d_store  = 1'b0;
        if (i_stat.halted) begin
            d_status = ST_HALT;
        end else begin
            unique case (i_stat.cmd)
                CMD_PUSH: begin
                    if (i_stat.sp_full) begin
                        d_status = ST_OVER;
                    end else begin
                        d_wr   = 1'b1;
                        d_wsel = ADDR_SP;
                        d_spop = SP_INC;
                        d_top  = TOP_RES;
                    end
                end
                CMD_STORE: begin
                    if (i_stat.sp_zero) begin
                        d_status = ST_UNDER;
                    end else begin
                        d_spop  = SP_DEC;
                        d_top   = TOP_NEXT;
                        d_store = 1'b1;
                    end
                end
                CMD_NOT: begin
                    if (i_stat.sp_zero) begin
                        d_status = ST_UNDER;
                    end else begin
                        d_wr   = 1'b1;
                        d_wsel = ADDR_TOP;
                        d_top  = TOP_RES;
                    end
                end
                default: begin
                    if (i_stat.sp_lt2) begin
                        d_status = ST_UNDER;
                    end else if (i_stat.cmd == CMD_DIV && i_stat.b_zero) begin
                        d_status = ST_DIVZ;
                    end else begin
                        d_wr   = 1'b1;
                        d_wsel = ADDR_NEXT;
                        d_spop = SP_DEC;
                        d_top  = TOP_RES;
                    end
                end
            endcase
        end
        d_unit = (d_status == ST_OK) && (i_stat.cmd inside {CMD_MUL, CMD_DIV});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state          = r_state;
        o_in_ready       = 1'b0;
        o_cmd            = '0;
        o_cmd.rd_sel     = ADDR_TOP;
        o_cmd.wr_sel     = d_wsel;
        o_cmd.sp_op      = d_spop;
        o_cmd.top_sel    = d_top;
        o_cmd.store_en   = d_store;
        o_cmd.status     = d_status;
        o_cmd.set_err    = (d_status inside {ST_UNDER, ST_DIVZ, ST_OVER});
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.cap_in = 1'b1;
                    n_state      = S_RD_TOP;
                end
            end
            S_RD_TOP: begin
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_sel = ADDR_TOP;
                n_state      = S_RD_NEXT;
            end
            S_RD_NEXT: begin
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_sel = ADDR_NEXT;
                o_cmd.cap_b  = 1'b1;
                n_state      = S_EXEC;
            end
            S_EXEC: begin
                if (d_unit) begin
                    o_cmd.unit_start = 1'b1;
                    n_state          = S_UNIT;
                end else begin
                    o_cmd.res_load = 1'b1;
                    n_state        = S_FINISH;
                end
            end
            S_UNIT: begin
                if (i_stat.unit_done) begin
                    o_cmd.res_load = 1'b1;
                    o_cmd.res_unit = 1'b1;
                    n_state        = S_FINISH;
                end
            end
            S_FINISH: begin
                if (i_stat.out_free) begin
                    o_cmd.commit = 1'b1;
                    o_cmd.wr_en  = d_wr;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// File: hdl/location_expression_stack_machine.sv
// A request passes through idle, top read, next read, execute, an optional multiply/divide wait and finish.
// Only one request is handled at a time; the next request is taken as soon as the
// controller returns to idle, while a finished result may still wait in the output register.
// The time per request is set by the registered stack memory read port (two reads per request)
// and by the iterative multiply/divide unit (3 steps for mul, 64 for div).
// Reset (synchronous, active low) empties the stack, clears the sticky error and the output valid flag.
module location_expression_stack_machine (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  lesm_pkg::t_in_req  i_in,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output lesm_pkg::t_out_res o_out
);
    import lesm_pkg::*;

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    lesm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (dp_stat),
        .o_cmd      (dp_cmd)
    );

    lesm_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_cmd       (dp_cmd),
        .o_stat      (dp_stat),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_out       (o_out)
    );

endmodule

// File: hdl/lesm_checker.sv
// Port-level checker for the stack machine, bound to the top level.
`include "location_expression_stack_machine_assert.svh"

module lesm_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_ready,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input lesm_pkg::t_out_res o_out
);
    import lesm_pkg::*;

    // A stalled result holds its value.
    `LESM_ASSERT_NEXT(a_out_hold, o_out_valid && !i_out_ready, o_out_valid && $stable(o_out))

    // Only one request is in flight at a time.
    `LESM_ASSERT_NEXT(a_one_in_flight, i_in_valid && o_in_ready, !o_in_ready)

    // A popped value is only reported by a successful store.
    `LESM_ASSERT_NOW(a_store_ok, o_out_valid && o_out.store_valid, o_out.status == ST_OK)

    // Without a popped value the stored field reads zero.
    `LESM_ASSERT_NOW(a_store_zero, o_out_valid && !o_out.store_valid, o_out.stored_value == '0)

    // Status codes stay within the defined set.
    `LESM_ASSERT_NOW(a_status_range, o_out_valid, o_out.status <= ST_HALT)

endmodule

bind location_expression_stack_machine lesm_checker u_lesm_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out       (o_out)
);
